[design/ymrc_pkg.sv]
package ymrc_pkg;

    localparam int unsigned DEFAULT_MAX_WIDTH = 8192;

    localparam int unsigned SAMPLE_W     = 8;
    localparam int unsigned LUMA_RES_W   = 9;
    localparam int unsigned CHROMA_RES_W = 10;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 14;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 14'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION   = 1'b0,
        CFG_IMAGE_WIDTH = 1'b1
    } t_cfg_reg;

    // working width for one plane value (y 0..255, chroma -256..255 and sums)
    typedef logic signed [9:0] t_pv;

    localparam t_pv LUMA_BORDER   = 10'sd128;
    localparam t_pv CHROMA_BORDER = 10'sd0;

    // line buffer word: y in bits 7:0, cg in 16:8, co in 25:17
    typedef struct packed {
        logic signed [8:0] co;
        logic signed [8:0] cg;
        logic [7:0]        y;
    } t_px;

    // halving that truncates toward zero
    function automatic t_pv half(input t_pv v);
        t_pv s;
        s = v + {9'd0, v[9]};
        return s >>> 1;
    endfunction

    // median edge predictor
    function automatic t_pv med(input t_pv a, input t_pv b, input t_pv c);
        t_pv mx;
        t_pv mn;
        logic [10:0] s;
        mx = (a > b) ? a : b;
        mn = (a < b) ? a : b;
        s  = {a[9], a} + {b[9], b} - {c[9], c};
        if (c >= mx) begin
            return mn;
        end else if (c <= mn) begin
            return mx;
        end
        return s[9:0];
    endfunction

    function automatic logic [7:0] clamp_u8(input logic signed [11:0] v);
        if (v < 12'sd0) begin
            return 8'd0;
        end else if (v > 12'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

[design/ycgco_med_residual_codec_top.sv]
// Lossless reversible YCgCo with a median edge predictor, one pixel per transaction in
// raster order. With direction 0 each RGB pixel is transformed to Y, Cg, Co and the block
// returns the three residuals against the predictor built from the left, top and top-left
// neighbors of the same plane (border neighbors read as 128 for Y and 0 for chroma); with
// direction 1 the residuals are added back, each plane saturates, and the clamped RGB is
// returned. The fields of the unused direction read as zero. frame_start restarts at row 0,
// column 0; row_end flags the last pixel of each row. The block sustains one pixel per
// clock unless the result side stalls: the row above lives in a single-port-read line
// buffer of MAX_WIDTH words, read into a register at the column of the accepted pixel,
// and the left neighbor loops back through a register. The line buffer needs no
// clearing after reset; configuration must be written only while no pixel is in flight.
module ycgco_med_residual_codec_top #(
    parameter int unsigned MAX_WIDTH = ymrc_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ymrc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ymrc_pkg::CFG_DATA_W-1:0]         i_cfg_data,

    // pixel input channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_frame_start,
    input  logic [ymrc_pkg::SAMPLE_W-1:0]           i_red,
    input  logic [ymrc_pkg::SAMPLE_W-1:0]           i_green,
    input  logic [ymrc_pkg::SAMPLE_W-1:0]           i_blue,
    input  logic signed [ymrc_pkg::LUMA_RES_W-1:0]  i_luma_residual_in,
    input  logic signed [ymrc_pkg::CHROMA_RES_W-1:0] i_cg_residual_in,
    input  logic signed [ymrc_pkg::CHROMA_RES_W-1:0] i_co_residual_in,

    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ymrc_pkg::LUMA_RES_W-1:0]  o_luma_residual,
    output logic signed [ymrc_pkg::CHROMA_RES_W-1:0] o_cg_residual,
    output logic signed [ymrc_pkg::CHROMA_RES_W-1:0] o_co_residual,
    output logic [ymrc_pkg::SAMPLE_W-1:0]           o_red_out,
    output logic [ymrc_pkg::SAMPLE_W-1:0]           o_green_out,
    output logic [ymrc_pkg::SAMPLE_W-1:0]           o_blue_out,
    output logic                                    o_row_end
);
    import ymrc_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    // compare width covers both the column count plus one and the width register
    localparam int unsigned CMP_W = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;

    // pixel waiting for its line buffer word
    typedef struct packed {
        logic                           has_left;
        logic                           has_top;
        logic                           row_end;
        logic                           fwd;
        logic [COL_W-1:0]               col;
        logic [SAMPLE_W-1:0]            red;
        logic [SAMPLE_W-1:0]            green;
        logic [SAMPLE_W-1:0]            blue;
        logic signed [LUMA_RES_W-1:0]   luma_res;
        logic signed [CHROMA_RES_W-1:0] cg_res;
        logic signed [CHROMA_RES_W-1:0] co_res;
    } t_s1;

    // configuration registers
    logic                  r_dir;
    logic [CFG_DATA_W-1:0] r_width;

    // scan position
    logic [COL_W-1:0]      r_col;
    logic                  r_first_row;
    logic [COL_W-1:0]      n_col;
    logic                  n_first_row;

    // line buffer and its read side
    t_px                   r_mem [MAX_WIDTH];
    t_px                   r_rd;
    t_px                   r_fwd_data;

    // neighbor registers
    t_px                   r_left;
    t_px                   r_tl;

    // compute stage
    logic                  r_s1_valid;
    t_s1                   r_s1;

    // output register
    logic                  r_out_valid;
    logic signed [LUMA_RES_W-1:0]   r_luma_res;
    logic signed [CHROMA_RES_W-1:0] r_cg_res;
    logic signed [CHROMA_RES_W-1:0] r_co_res;
    logic [SAMPLE_W-1:0]   r_red;
    logic [SAMPLE_W-1:0]   r_green;
    logic [SAMPLE_W-1:0]   r_blue;
    logic                  r_row_end;

    logic                  accept;
    logic                  s1_commit;
    logic [COL_W-1:0]      col0;
    logic                  first0;
    logic [CMP_W-1:0]      col_inc;
    logic [CMP_W-1:0]      eff_width;
    logic [CMP_W-1:0]      width_ext;
    logic                  row_end0;

    t_px                   top_px;
    t_pv                   pl_left   [3];
    t_pv                   pl_top    [3];
    t_pv                   pl_tl     [3];
    t_pv                   border    [3];
    t_pv                   pred      [3];
    t_pv                   cur_e     [3];
    t_pv                   cur_d     [3];
    t_pv                   cur       [3];
    t_pv                   res       [3];
    logic signed [10:0]    dsum      [3];
    t_pv                   co_e;
    t_pv                   t_e;
    t_pv                   cg_e;
    t_pv                   hcg_d;
    t_pv                   hco_d;
    logic signed [11:0]    t_d;
    logic signed [11:0]    g_d;
    logic signed [11:0]    b_d;
    logic signed [11:0]    r_d;
    t_px                   cur_px;

    // ---------------------------------------------------------------------
    // configuration: always ready; the user, not the block, ensures it is written only while idle
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DIRECTION:   r_dir   <= i_cfg_data[0];
                CFG_IMAGE_WIDTH: r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // handshakes: compute stage advances into the output register when that
    // register is empty or being drained in the same cycle
    // ---------------------------------------------------------------------
    assign s1_commit  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_commit;
    assign accept     = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------------
    // scan position of the incoming pixel
    // ---------------------------------------------------------------------
    // width 0 acts as 1, anything above the buffer depth as the depth
    assign width_ext = CMP_W'(r_width);
    always_comb begin
        if (r_width == '0) begin
            eff_width = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
    end

    assign col0     = i_frame_start ? '0 : r_col;
    assign first0   = i_frame_start | r_first_row;
    assign col_inc  = CMP_W'(col0) + CMP_W'(1);
    assign row_end0 = col_inc >= eff_width;

    always_comb begin
        n_col       = row_end0 ? '0 : col_inc[COL_W-1:0];
        n_first_row = row_end0 ? 1'b0 : first0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (accept) begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

    // ---------------------------------------------------------------------
    // line buffer: read the row above at accept, write back at commit
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_commit) begin
            r_mem[r_s1.col] <= cur_px;
        end
        if (accept) begin
            r_rd <= r_mem[col0];
        end
    end

    // a write to the entry being read in the same cycle returns old data,
    // so the written word is kept aside and used instead
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= cur_px;
        end
    end

    // ---------------------------------------------------------------------
    // compute stage register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_commit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.has_left <= col0 != '0;
            r_s1.has_top  <= !first0;
            r_s1.row_end  <= row_end0;
            r_s1.fwd      <= s1_commit && (r_s1.col == col0);
            r_s1.col      <= col0;
            r_s1.red      <= i_red;
            r_s1.green    <= i_green;
            r_s1.blue     <= i_blue;
            r_s1.luma_res <= i_luma_residual_in;
            r_s1.cg_res   <= i_cg_residual_in;
            r_s1.co_res   <= i_co_residual_in;
        end
    end

    // ---------------------------------------------------------------------
    // prediction and transform
    // ---------------------------------------------------------------------
    assign top_px = r_s1.fwd ? r_fwd_data : r_rd;

    always_comb begin
        border[0]  = LUMA_BORDER;
        border[1]  = CHROMA_BORDER;
        border[2]  = CHROMA_BORDER;

        pl_left[0] = {2'b00, r_left.y};
        pl_left[1] = {r_left.cg[8], r_left.cg};
        pl_left[2] = {r_left.co[8], r_left.co};
        pl_top[0]  = {2'b00, top_px.y};
        pl_top[1]  = {top_px.cg[8], top_px.cg};
        pl_top[2]  = {top_px.co[8], top_px.co};
        pl_tl[0]   = {2'b00, r_tl.y};
        pl_tl[1]   = {r_tl.cg[8], r_tl.cg};
        pl_tl[2]   = {r_tl.co[8], r_tl.co};

        for (int k = 0; k < 3; k++) begin
            pred[k] = med(r_s1.has_left ? pl_left[k] : border[k],
                          r_s1.has_top ? pl_top[k] : border[k],
                          (r_s1.has_left && r_s1.has_top) ? pl_tl[k] : border[k]);
        end

        // forward transform
        co_e     = {2'b00, r_s1.red} - {2'b00, r_s1.blue};
        t_e      = {2'b00, r_s1.blue} + half(co_e);
        cg_e     = {2'b00, r_s1.green} - t_e;
        cur_e[0] = t_e + half(cg_e);
        cur_e[1] = cg_e;
        cur_e[2] = co_e;

        // residual plus prediction, saturated per plane
        dsum[0] = {{2{r_s1.luma_res[8]}}, r_s1.luma_res} + {pred[0][9], pred[0]};
        dsum[1] = {r_s1.cg_res[9], r_s1.cg_res} + {pred[1][9], pred[1]};
        dsum[2] = {r_s1.co_res[9], r_s1.co_res} + {pred[2][9], pred[2]};

        if (dsum[0] < 11'sd0) begin
            cur_d[0] = 10'sd0;
        end else if (dsum[0] > 11'sd255) begin
            cur_d[0] = 10'sd255;
        end else begin
            cur_d[0] = dsum[0][9:0];
        end
        for (int k = 1; k < 3; k++) begin
            if (dsum[k] < -11'sd256) begin
                cur_d[k] = -10'sd256;
            end else if (dsum[k] > 11'sd255) begin
                cur_d[k] = 10'sd255;
            end else begin
                cur_d[k] = dsum[k][9:0];
            end
        end

        for (int k = 0; k < 3; k++) begin
            cur[k] = r_dir ? cur_d[k] : cur_e[k];
            res[k] = cur_e[k] - pred[k];
        end

        // inverse transform; halves are sign extended from their own sign,
        // since half of minus one is zero
        hcg_d = half(cur_d[1]);
        hco_d = half(cur_d[2]);
        t_d = {{2{cur_d[0][9]}}, cur_d[0]} - {{2{hcg_d[9]}}, hcg_d};
        g_d = {{2{cur_d[1][9]}}, cur_d[1]} + t_d;
        b_d = t_d - {{2{hco_d[9]}}, hco_d};
        r_d = b_d + {{2{cur_d[2][9]}}, cur_d[2]};

        cur_px.y  = cur[0][7:0];
        cur_px.cg = cur[1][8:0];
        cur_px.co = cur[2][8:0];
    end

    // neighbors for the next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_tl   <= '0;
        end else if (s1_commit) begin
            r_left <= cur_px;
            r_tl   <= top_px;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s1_commit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_commit) begin
            r_luma_res <= r_dir ? '0 : res[0][LUMA_RES_W-1:0];
            r_cg_res   <= r_dir ? '0 : res[1];
            r_co_res   <= r_dir ? '0 : res[2];
            r_red      <= r_dir ? clamp_u8(r_d) : '0;
            r_green    <= r_dir ? clamp_u8(g_d) : '0;
            r_blue     <= r_dir ? clamp_u8(b_d) : '0;
            r_row_end  <= r_s1.row_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_luma_residual = r_luma_res;
    assign o_cg_residual   = r_cg_res;
    assign o_co_residual   = r_co_res;
    assign o_red_out       = r_red;
    assign o_green_out     = r_green;
    assign o_blue_out      = r_blue;
    assign o_row_end       = r_row_end;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a row end always wraps the column and leaves the first row
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && row_end0 |=> (r_col == '0) && !r_first_row)
        else $error("column did not wrap after row end");

    // the input side only holds off while a pixel is parked in the compute stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled without a blocked pixel");

    // back-to-back hits on one line buffer entry only happen at column zero
    a_fwd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.fwd |-> r_s1.col == '0)
        else $error("line buffer forward away from column zero");

    // the column never runs past the buffer
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_col) < CMP_W'(MAX_WIDTH))
        else $error("column beyond line buffer depth");

    // a delivered result carries only one direction's fields
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_red_out != '0 || o_green_out != '0 || o_blue_out != '0)
        |-> o_luma_residual == '0 && o_cg_residual == '0 && o_co_residual == '0)
        else $error("both result groups nonzero");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import ymrc_pkg::*;

    // clock period is 12 ns, so a half period of 6
    localparam int MAX_W       = DEFAULT_MAX_WIDTH;
    localparam int RST_CYCLES  = 8;
    localparam int SETTLE      = 4;        // idle wait once all results are checked
    localparam int LIMIT       = 600000;   // hang guard, far above the slowest legal run
    localparam int RANDOM_ITEMS = 1560;

    // one pixel transaction as driven on the input channel
    typedef struct packed {
        logic              frame_start;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [8:0] luma_residual_in;
        logic signed [9:0] cg_residual_in;
        logic signed [9:0] co_residual_in;
    } t_pixel;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic signed [8:0] luma_residual;
        logic signed [9:0] cg_residual;
        logic signed [9:0] co_residual;
        logic [7:0]        red_out;
        logic [7:0]        green_out;
        logic [7:0]        blue_out;
        logic              row_end;
    } t_result;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // configuration channel
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_reg         cfg_index = CFG_DIRECTION;
    logic [13:0]      cfg_data = '0;

    // pixel input channel, all fields known from time zero
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             frame_start = 1'b0;
    logic [7:0]       red = '0;
    logic [7:0]       green = '0;
    logic [7:0]       blue = '0;
    logic signed [8:0] luma_res_in = '0;
    logic signed [9:0] cg_res_in = '0;
    logic signed [9:0] co_res_in = '0;

    // result channel
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic signed [8:0] luma_res_out;
    logic signed [9:0] cg_res_out;
    logic signed [9:0] co_res_out;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic             row_end;

    // predictor state: line buffer, neighbors, raster position and settings
    t_px              line_mem [0:MAX_W-1];
    t_px              left_px = '0;
    t_px              upleft_px = '0;
    int               col_pos = 0;
    bit               on_first_row = 1'b1;
    bit               mode_decode = 1'b0;
    logic [13:0]      row_width = WIDTH_RESET;

    // results predicted for accepted pixels, oldest first
    t_result          predicted_pixels [$];

    int               fail_count = 0;
    int               stall_left = 0;
    bit               no_idle = 1'b0;   // both sides run back to back while set
    int unsigned      cycle_count = 0;

    ycgco_med_residual_codec_top uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_frame_start      (frame_start),
        .i_red              (red),
        .i_green            (green),
        .i_blue             (blue),
        .i_luma_residual_in (luma_res_in),
        .i_cg_residual_in   (cg_res_in),
        .i_co_residual_in   (co_res_in),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_luma_residual    (luma_res_out),
        .o_cg_residual      (cg_res_out),
        .o_co_residual      (co_res_out),
        .o_red_out          (red_out),
        .o_green_out        (green_out),
        .o_blue_out         (blue_out),
        .o_row_end          (row_end)
    );

    always #6 clk = ~clk;

    // hang guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("ycgco_med_residual_codec_top test failed");
            $finish;
        end
    end

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // standard median edge predictor: a left, b top, c top-left
    function automatic int median_edge(input int a, input int b, input int c);
        int mx;
        int mn;
        mx = (a > b) ? a : b;
        mn = (a < b) ? a : b;
        if (c >= mx) begin
            return mn;
        end else if (c <= mn) begin
            return mx;
        end
        return a + b - c;
    endfunction

    function automatic t_pixel make_pixel(input bit fs, input int r, input int g, input int b,
                                          input int yr, input int cgr, input int cor);
        t_pixel px;
        px.frame_start      = fs;
        px.red              = r[7:0];
        px.green            = g[7:0];
        px.blue             = b[7:0];
        px.luma_residual_in = yr[8:0];
        px.cg_residual_in   = cgr[9:0];
        px.co_residual_in   = cor[9:0];
        return px;
    endfunction

    // samples always random; residuals half full range, half close to zero
    function automatic t_pixel random_pixel(input bit fs);
        t_pixel px;
        px.frame_start = fs;
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            px.luma_residual_in = 9'($urandom);
            px.cg_residual_in   = 10'($urandom);
            px.co_residual_in   = 10'($urandom);
        end else begin
            px.luma_residual_in = 9'(int'($urandom_range(0, 16)) - 8);
            px.cg_residual_in   = 10'(int'($urandom_range(0, 16)) - 8);
            px.co_residual_in   = 10'(int'($urandom_range(0, 16)) - 8);
        end
        return px;
    endfunction

    // expected result of one accepted pixel; advances the predictor state
    task automatic predict_pixel(input t_pixel px, output t_result res);
        int eff_w;
        int col;
        int k;
        int p;
        int t;
        int rr;
        int gg;
        int bb;
        int cur [3];
        int lft [3];
        int abv [3];
        int ulf [3];
        int din [3];
        int resid [3];
        int brd;
        bit has_left;
        bit has_top;
        t_px above;
        t_px cur_px;
        res = '0;
        if (px.frame_start) begin
            col_pos = 0;
            on_first_row = 1'b1;
        end
        // width zero behaves as one, oversize clips to the buffer depth
        eff_w = (row_width == 0) ? 1 : ((row_width > MAX_W) ? MAX_W : int'(row_width));
        col = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        has_left = (col > 0);
        has_top = !on_first_row;
        above = line_mem[col];
        lft[0] = left_px.y;   lft[1] = $signed(left_px.cg);   lft[2] = $signed(left_px.co);
        abv[0] = above.y;     abv[1] = $signed(above.cg);     abv[2] = $signed(above.co);
        ulf[0] = upleft_px.y; ulf[1] = $signed(upleft_px.cg); ulf[2] = $signed(upleft_px.co);
        din[0] = $signed(px.luma_residual_in);
        din[1] = $signed(px.cg_residual_in);
        din[2] = $signed(px.co_residual_in);

        // forward reversible transform, halving toward zero
        if (!mode_decode) begin
            rr = px.red;
            gg = px.green;
            bb = px.blue;
            cur[2] = rr - bb;
            t = bb + cur[2] / 2;
            cur[1] = gg - t;
            cur[0] = t + cur[1] / 2;
        end

        for (k = 0; k < 3; k++) begin
            brd = (k == 0) ? int'(LUMA_BORDER) : int'(CHROMA_BORDER);
            p = median_edge(has_left ? lft[k] : brd, has_top ? abv[k] : brd,
                            (has_left && has_top) ? ulf[k] : brd);
            if (!mode_decode) begin
                resid[k] = cur[k] - p;
            end else begin
                resid[k] = 0;
                cur[k] = (k == 0) ? clip(din[k] + p, 0, 255) : clip(din[k] + p, -256, 255);
            end
        end
        res.luma_residual = resid[0][8:0];
        res.cg_residual   = resid[1][9:0];
        res.co_residual   = resid[2][9:0];

        // inverse transform with rgb clamped
        if (mode_decode) begin
            t  = cur[0] - cur[1] / 2;
            gg = cur[1] + t;
            bb = t - cur[2] / 2;
            rr = bb + cur[2];
            res.red_out   = 8'(clip(rr, 0, 255));
            res.green_out = 8'(clip(gg, 0, 255));
            res.blue_out  = 8'(clip(bb, 0, 255));
        end

        cur_px.y  = cur[0][7:0];
        cur_px.cg = cur[1][8:0];
        cur_px.co = cur[2][8:0];
        line_mem[col] = cur_px;
        upleft_px = above;
        left_px = cur_px;

        if (col + 1 >= eff_w) begin
            res.row_end = 1'b1;
            col_pos = 0;
            on_first_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
    endtask

    // send one pixel after a random gap, predict once it is taken
    task automatic push_pixel(input t_pixel px);
        int gap;
        t_result want;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_start <= px.frame_start;
        red         <= px.red;
        green       <= px.green;
        blue        <= px.blue;
        luma_res_in <= px.luma_residual_in;
        cg_res_in   <= px.cg_residual_in;
        co_res_in   <= px.co_residual_in;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_pixel(px, want);
        predicted_pixels.push_back(want);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (predicted_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write both registers back to back while the block is idle
    task automatic set_mode(input bit dir, input int width);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DIRECTION;
        cfg_data  <= {13'd0, dir};
        do @(posedge clk); while (!cfg_ready);
        mode_decode = dir;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= width[13:0];
        do @(posedge clk); while (!cfg_ready);
        row_width = width[13:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result side: check each accepted transaction, then stall at random
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_pixels.size() == 0) begin
                $error("result transaction with no pixel outstanding");
                fail_count++;
            end else begin
                want = predicted_pixels.pop_front();
                check_field("luma_residual", $signed(want.luma_residual), $signed(luma_res_out));
                check_field("cg_residual", $signed(want.cg_residual), $signed(cg_res_out));
                check_field("co_residual", $signed(want.co_residual), $signed(co_res_out));
                check_field("red_out", want.red_out, red_out);
                check_field("green_out", want.green_out, green_out);
                check_field("blue_out", want.blue_out, blue_out);
                check_field("row_end", want.row_end, row_end);
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        out_stall <= (stall_left > 0);
    end

    // encode: sample extremes, odd negative chroma for the halving, 9 pixels at width 4
    task automatic test_encode_corners();
        set_mode(1'b0, 4);
        push_pixel(make_pixel(1'b1, 0, 0, 0, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 255, 255, 255, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 255, 0, 0, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 0, 255, 0, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 0, 0, 255, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 0, 255, 255, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 255, 0, 255, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 1, 0, 254, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 128, 127, 129, 0, 0, 0));
    endtask

    // decode: residual extremes drive every plane into saturation
    task automatic test_decode_corners();
        set_mode(1'b1, 3);
        push_pixel(make_pixel(1'b1, 0, 0, 0, 255, 511, 511));
        push_pixel(make_pixel(1'b0, 0, 0, 0, -256, -512, -512));
        push_pixel(make_pixel(1'b0, 0, 0, 0, 0, 0, 0));
        push_pixel(make_pixel(1'b0, 0, 0, 0, 255, -512, 511));
        push_pixel(make_pixel(1'b0, 0, 0, 0, -256, 511, -512));
        push_pixel(make_pixel(1'b0, 0, 0, 0, 1, -1, 1));
        push_pixel(make_pixel(1'b0, 0, 0, 0, 0, 0, 0));
    endtask

    // width shrunk past the current column, then direction flipped mid image
    task automatic test_mid_image_changes();
        set_mode(1'b0, 8);
        for (int i = 0; i < 14; i++) push_pixel(random_pixel(i == 0));
        set_mode(1'b0, 3);
        push_pixel(random_pixel(1'b0));     // column 6 already past width, ends the row
        push_pixel(random_pixel(1'b0));
        set_mode(1'b1, 3);
        for (int i = 0; i < 4; i++) push_pixel(random_pixel(1'b0));
    endtask

    // width zero and one, oversize width, and the full buffer depth
    task automatic test_width_limits();
        set_mode(1'b0, 0);
        for (int i = 0; i < 4; i++) push_pixel(random_pixel(i == 0));
        set_mode(1'b1, 1);
        for (int i = 0; i < 3; i++) push_pixel(random_pixel(i == 0));
        // all-ones width clips to full depth, so a short run stays inside its row
        set_mode(1'b0, 14'h3FFF);
        for (int i = 0; i < 12; i++) push_pixel(random_pixel(i == 0));
        set_mode(1'b1, MAX_W);
        for (int i = 0; i < 4; i++) push_pixel(random_pixel(i == 0));
    endtask

    // well-formed images of random size and mode, with stray frame starts and
    // occasional mid-image shrink or direction flip
    task automatic test_random_stream(input int n_items);
        int sent;
        int w;
        int eff;
        int total;
        int change_at;
        bit dir;
        bit pressured;
        sent = 0;
        pressured = 1'b0;
        while (sent < n_items) begin
            dir = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: begin
                    w = 0;
                end
                1: begin
                    w = $urandom_range(65, 300);
                end
                2, 3: begin
                    w = $urandom_range(17, 64);
                end
                default: begin
                    w = $urandom_range(1, 16);
                end
            endcase
            // growing width always comes with a frame start on the next pixel
            set_mode(dir, w);
            eff = (w == 0) ? 1 : w;
            total = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
            if (total > 400) begin
                total = 400;
            end
            change_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, total) : -1;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < total; i++) begin
                if (i == change_at) begin
                    if ($urandom_range(0, 1) == 1) begin
                        dir = !dir;
                    end else begin
                        w = $urandom_range(0, w);
                    end
                    set_mode(dir, w);
                end
                // hold the sender once until the pipe is empty
                if (!pressured && sent >= n_items / 2) begin
                    drain();
                    pressured = 1'b1;
                end
                push_pixel(random_pixel(i == 0 || $urandom_range(0, 63) == 0));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_corners();
        test_decode_corners();
        test_mid_image_changes();
        test_width_limits();
        test_random_stream(RANDOM_ITEMS);
        // flush the tail
        in_valid <= 1'b0;
        while (predicted_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("ycgco_med_residual_codec_top test passed");
        end else begin
            $display("ycgco_med_residual_codec_top test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ymrc_pkg.sv
design/ycgco_med_residual_codec_top.sv
verif/testbench.sv
